>>> hw/rtl/f32_exp_nonpositive_poly5_top_macros.svh
// assertion macros for the single-precision exp pipeline
// depends on signals named clock and reset in the module that uses them
`ifndef F32_EXP_NONPOSITIVE_POLY5_TOP_MACROS_SVH
`define F32_EXP_NONPOSITIVE_POLY5_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define F32E_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("f32e check failed");
// next-cycle implication
`define F32E_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("f32e check failed");
`else
`define F32E_ASSERT_NOW(label, ante, cons)
`define F32E_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/f32e_pkg.sv
// constants, types and helper functions of the single-precision exp pipeline
// no dependencies
`default_nettype none
package f32e_pkg;
   typedef logic [31:0] f32_type;

   localparam f32_type MAGIC_BIAS  = 32'h4B40007F;
   localparam f32_type NEG_MAGIC   = 32'hCB40007F;
   localparam f32_type ONE_BITS    = 32'h3F800000;
   localparam f32_type LOG2E       = 32'h3FB8AA3B;
   localparam f32_type MINUS_LN2   = 32'hBF317218;
   localparam f32_type COEF1       = 32'h3F7FFFFB;
   localparam f32_type COEF2       = 32'h3EFFFEE3;
   localparam f32_type COEF3       = 32'h3E2AAD40;
   localparam f32_type COEF4       = 32'h3D2B9D0D;
   localparam f32_type COEF5       = 32'h3C07CFCE;
   localparam f32_type NEG_ZERO    = 32'h80000000;
   localparam f32_type DEFAULT_NAN = 32'hFFC00000;
   localparam f32_type QUIET_BIT   = 32'h00400000;
   localparam logic [30:0] INF_MAG    = 31'h7F800000;
   localparam logic [30:0] CUTOFF_MAG = 31'h42AEAC4F;
   localparam int SCALE_SHIFT = 23;

   // position of the highest set bit, zero for zero
   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] pos;
      pos = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) pos = i[5:0];
      end
      return pos;
   endfunction

   // significand of a finite value
   function automatic logic [23:0] sig_of(input f32_type v);
      return {(v[30:23] != 8'd0), v[22:0]};
   endfunction

   // exponent of the significand lsb
   function automatic logic signed [11:0] exp_of(input f32_type v);
      logic signed [11:0] e;
      if (v[30:23] == 8'd0) e = -12'sd149;
      else e = $signed({4'b0, v[30:23]}) - 12'sd150;
      return e;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/f32e_chan_if.sv
// valid/ready channel interfaces for request and response words
// no dependencies
`default_nettype none
interface f32e_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] x_bits;
   logic        last_in;
   modport source (output valid, output x_bits, output last_in, input ready);
   modport sink (input valid, input x_bits, input last_in, output ready);
endinterface

interface f32e_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] y_bits;
   logic        last_out;
   modport source (output valid, output y_bits, output last_out, input ready);
   modport sink (input valid, input y_bits, input last_out, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/f32e_fma.sv
// five-stage binary32 fused multiply-add, round to nearest even, subnormals kept
// depends on f32e_pkg and the assertion macro header
`default_nettype none
`include "f32_exp_nonpositive_poly5_top_macros.svh"
module f32e_fma #(
   parameter int SB_W = 1
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    en,
   input  wire                    in_vld,
   input  wire  f32e_pkg::f32_type a,
   input  wire  f32e_pkg::f32_type b,
   input  wire  f32e_pkg::f32_type c,
   input  wire  [SB_W-1:0]        side_in,
   output logic                   out_vld,
   output f32e_pkg::f32_type      out_bits,
   output logic [SB_W-1:0]        side_out
);
   import f32e_pkg::*;

   // stage 1: specials, decode, multiply
   logic a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero, sp;
   logic s1_spec_in;
   f32_type s1_sbits_in;
   logic s1_vld_ff, s1_spec_ff, s1_sp_ff, s1_sc_ff, s1_cz_ff;
   f32_type s1_sbits_ff;
   logic [47:0] s1_mp_ff;
   logic [23:0] s1_mc_ff;
   logic signed [11:0] s1_ep_ff, s1_ec_ff;
   logic [SB_W-1:0] s1_side_ff;

   always_comb begin
      a_nan = a[30:0] > INF_MAG;
      b_nan = b[30:0] > INF_MAG;
      c_nan = c[30:0] > INF_MAG;
      a_inf = a[30:0] == INF_MAG;
      b_inf = b[30:0] == INF_MAG;
      c_inf = c[30:0] == INF_MAG;
      a_zero = a[30:0] == 31'd0;
      b_zero = b[30:0] == 31'd0;
      c_zero = c[30:0] == 31'd0;
      sp = a[31] ^ b[31];
      s1_spec_in = 1'b1;
      s1_sbits_in = '0;
      if (a_nan) s1_sbits_in = a | QUIET_BIT;
      else if (b_nan) s1_sbits_in = b | QUIET_BIT;
      else if (c_nan) s1_sbits_in = c | QUIET_BIT;
      else if ((a_inf && b_zero) || (b_inf && a_zero)) s1_sbits_in = DEFAULT_NAN;
      else if (a_inf || b_inf) begin
         s1_sbits_in = (c_inf && (c[31] != sp)) ? DEFAULT_NAN : {sp, INF_MAG};
      end else if (c_inf) s1_sbits_in = c;
      else if (a_zero || b_zero) begin
         if (!c_zero) s1_sbits_in = c;
         else s1_sbits_in = (sp == c[31]) ? c : 32'd0;
      end else s1_spec_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= in_vld;
      if (en) begin
         s1_spec_ff  <= s1_spec_in;
         s1_sbits_ff <= s1_sbits_in;
         s1_mp_ff    <= sig_of(a) * sig_of(b);
         s1_ep_ff    <= exp_of(a) + exp_of(b);
         s1_mc_ff    <= sig_of(c);
         s1_ec_ff    <= exp_of(c);
         s1_sp_ff    <= sp;
         s1_sc_ff    <= c[31];
         s1_cz_ff    <= c_zero;
         s1_side_ff  <= side_in;
      end
   end

   // stage 2: normalize both terms to bit 61, swap, align with sticky
   logic [5:0] lsp, lsc, dsh;
   logic [63:0] mpn, mcn, sml_raw, s2_big_in, s2_sml_in;
   logic signed [11:0] epn, ecn, s2_eb_in, es, dd;
   logic prod_big, s2_sbig_in, s2_ssml_in;
   logic s2_vld_ff, s2_spec_ff, s2_sbig_ff, s2_ssml_ff;
   f32_type s2_sbits_ff;
   logic [63:0] s2_big_ff, s2_sml_ff;
   logic signed [11:0] s2_eb_ff;
   logic [SB_W-1:0] s2_side_ff;

   always_comb begin
      lsp = 6'd61 - msb64({16'd0, s1_mp_ff});
      lsc = 6'd61 - msb64({40'd0, s1_mc_ff});
      mpn = {16'd0, s1_mp_ff} << lsp;
      mcn = {40'd0, s1_mc_ff} << lsc;
      epn = s1_ep_ff - $signed({6'd0, lsp});
      ecn = s1_ec_ff - $signed({6'd0, lsc});
      prod_big = s1_cz_ff || (epn >= ecn);
      s2_big_in  = prod_big ? mpn : mcn;
      s2_eb_in   = prod_big ? epn : ecn;
      s2_sbig_in = prod_big ? s1_sp_ff : s1_sc_ff;
      s2_ssml_in = prod_big ? s1_sc_ff : s1_sp_ff;
      sml_raw    = s1_cz_ff ? 64'd0 : (prod_big ? mcn : mpn);
      es         = prod_big ? ecn : epn;
      dd         = s2_eb_in - es;
      dsh        = dd[5:0];
      if (s1_cz_ff) s2_sml_in = 64'd0;
      else if (dd >= 12'sd63) s2_sml_in = {63'd0, |sml_raw};
      else s2_sml_in = (sml_raw >> dsh)
         | {63'd0, |(sml_raw & ((64'd1 << dsh) - 64'd1))};
   end

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
      if (en) begin
         s2_spec_ff  <= s1_spec_ff;
         s2_sbits_ff <= s1_sbits_ff;
         s2_big_ff   <= s2_big_in;
         s2_sml_ff   <= s2_sml_in;
         s2_eb_ff    <= s2_eb_in;
         s2_sbig_ff  <= s2_sbig_in;
         s2_ssml_ff  <= s2_ssml_in;
         s2_side_ff  <= s1_side_ff;
      end
   end

   // stage 3: signed magnitude add
   logic same, big_ge;
   logic [63:0] s3_r_in;
   logic s3_sign_in;
   logic s3_vld_ff, s3_spec_ff, s3_sign_ff;
   f32_type s3_sbits_ff;
   logic [63:0] s3_r_ff;
   logic signed [11:0] s3_e_ff;
   logic [SB_W-1:0] s3_side_ff;

   always_comb begin
      same = s2_sbig_ff == s2_ssml_ff;
      big_ge = s2_big_ff >= s2_sml_ff;
      if (same) begin
         s3_r_in = s2_big_ff + s2_sml_ff;
         s3_sign_in = s2_sbig_ff;
      end else if (big_ge) begin
         s3_r_in = s2_big_ff - s2_sml_ff;
         s3_sign_in = s2_sbig_ff;
      end else begin
         s3_r_in = s2_sml_ff - s2_big_ff;
         s3_sign_in = s2_ssml_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= s2_vld_ff;
      if (en) begin
         s3_spec_ff  <= s2_spec_ff;
         s3_sbits_ff <= s2_sbits_ff;
         s3_r_ff     <= s3_r_in;
         s3_sign_ff  <= s3_sign_in;
         s3_e_ff     <= s2_eb_ff;
         s3_side_ff  <= s2_side_ff;
      end
   end

   // stage 4: leading one, result exponent, rounding shift
   logic [5:0] top;
   logic signed [11:0] s4_ev_in, s4_shift_in;
   logic s4_normal_in;
   logic s4_vld_ff, s4_spec_ff, s4_sign_ff, s4_zero_ff, s4_normal_ff, s4_ovf_ff;
   f32_type s4_sbits_ff;
   logic [63:0] s4_r_ff;
   logic signed [11:0] s4_ev_ff, s4_shift_ff;
   logic [SB_W-1:0] s4_side_ff;

   always_comb begin
      top = msb64(s3_r_ff);
      s4_ev_in = $signed({6'd0, top}) + s3_e_ff;
      s4_normal_in = s4_ev_in >= -12'sd126;
      s4_shift_in = s4_normal_in ? ($signed({6'd0, top}) - 12'sd23)
                                 : (-12'sd149 - s3_e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (en) s4_vld_ff <= s3_vld_ff;
      if (en) begin
         s4_spec_ff   <= s3_spec_ff;
         s4_sbits_ff  <= s3_sbits_ff;
         s4_sign_ff   <= s3_sign_ff;
         s4_zero_ff   <= s3_r_ff == 64'd0;
         s4_r_ff      <= s3_r_ff;
         s4_ev_ff     <= s4_ev_in;
         s4_normal_ff <= s4_normal_in;
         s4_ovf_ff    <= s4_normal_in && (s4_ev_in >= 12'sd128);
         s4_shift_ff  <= s4_shift_in;
         s4_side_ff   <= s3_side_ff;
      end
   end

   // stage 5: round to nearest even and pack
   logic [5:0] rsh, lsh;
   logic [63:0] m, low_mask;
   logic guard, sticky;
   logic [11:0] evb;
   logic [32:0] w;
   logic [30:0] mag;
   f32_type s5_bits_in;
   logic s5_vld_ff;
   f32_type s5_bits_ff;
   logic [SB_W-1:0] s5_side_ff;

   always_comb begin
      rsh = s4_shift_ff[5:0];
      lsh = 6'd0 - s4_shift_ff[5:0];
      low_mask = (64'd1 << (rsh - 6'd1)) - 64'd1;
      guard = 1'b0;
      sticky = 1'b0;
      if (s4_shift_ff <= 12'sd0) m = s4_r_ff << lsh;
      else if (s4_shift_ff >= 12'sd64) m = 64'd0;
      else begin
         m = s4_r_ff >> rsh;
         guard = s4_r_ff[rsh - 6'd1];
         sticky = |(s4_r_ff & low_mask);
         m = m + {63'd0, guard & (sticky | m[0])};
      end
      evb = s4_ev_ff + 12'sd126;
      w = ({25'd0, evb[7:0]} << SCALE_SHIFT) + {8'd0, m[24:0]};
      if (!s4_normal_ff) mag = m[30:0];
      else if (w >= {2'b0, INF_MAG}) mag = INF_MAG;
      else mag = w[30:0];
      if (s4_spec_ff) s5_bits_in = s4_sbits_ff;
      else if (s4_zero_ff) s5_bits_in = 32'd0;
      else if (s4_ovf_ff) s5_bits_in = {s4_sign_ff, INF_MAG};
      else s5_bits_in = {s4_sign_ff, mag};
   end

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (en) s5_vld_ff <= s4_vld_ff;
      if (en) begin
         s5_bits_ff <= s5_bits_in;
         s5_side_ff <= s4_side_ff;
      end
   end

   assign out_vld  = s5_vld_ff;
   assign out_bits = s5_bits_ff;
   assign side_out = s5_side_ff;

   // larger aligned term always carries its leading one at bit 61
   `F32E_ASSERT_NOW(a_big_norm, s2_vld_ff && !s2_spec_ff, s2_big_ff[61])
   // the magnitude sum never reaches bit 63
   `F32E_ASSERT_NOW(a_sum_fits, s3_vld_ff && !s3_spec_ff, !s3_r_ff[63])
   // a stalled pipe keeps its result word
   `F32E_ASSERT_NEXT(a_stall_hold, !en && s5_vld_ff, $stable(s5_bits_ff) && s5_vld_ff)
endmodule
`default_nettype wire

>>> hw/rtl/f32_exp_nonpositive_poly5_top.sv
// exp(x) for binary32 x: eight chained 5-stage FMA units,
// throughput one word per cycle; a stall on the response side freezes the pipe.
// reset (synchronous, active high) clears the valid bits of every stage;
// data registers are not reset.
// depends on f32e_pkg, f32e_chan_if, f32e_fma and the assertion macro header
`default_nettype none
`include "f32_exp_nonpositive_poly5_top_macros.svh"
module f32_exp_nonpositive_poly5_top (
   input wire       clock,
   input wire       reset,
   f32e_req_if.sink req_bus,
   f32e_rsp_if.source rsp_bus
);
   import f32e_pkg::*;

   logic en, cut;
   f32_type vn, s_in, n, t, p4, p5, p6, p7, ts, f;
   logic v1, v2, v3, v4, v4b, v5, v6, v7, v8;
   logic [33:0] sb1_in, sb1;
   logic [65:0] sb2_in, sb2, sb3, sb4;
   logic [97:0] sb5_in, sb5, sb6, sb7;
   logic [1:0] sb8;
   logic sb4b;

   // whole pipe advances unless the response word is held
   assign en = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = en;

   // below the denormal cutoff the result is +0
   assign cut = (req_bus.x_bits[30:0] <= INF_MAG) && req_bus.x_bits[31]
      && (req_bus.x_bits[30:0] > CUTOFF_MAG);
   assign sb1_in = {cut, req_bus.last_in, req_bus.x_bits};

   // n + bias = x*log2e + bias
   f32e_fma #(.SB_W(34)) u_vn (.clock, .reset, .en, .in_vld(req_bus.valid),
      .a(req_bus.x_bits), .b(LOG2E), .c(MAGIC_BIAS), .side_in(sb1_in),
      .out_vld(v1), .out_bits(vn), .side_out(sb1));

   // scale 2^n from the biased bits
   assign s_in = {vn[8:0], 23'd0};
   assign sb2_in = {sb1, s_in};

   // n = (n + bias) - bias
   f32e_fma #(.SB_W(66)) u_n (.clock, .reset, .en, .in_vld(v1),
      .a(vn), .b(ONE_BITS), .c(NEG_MAGIC), .side_in(sb2_in),
      .out_vld(v2), .out_bits(n), .side_out(sb2));

   // t = x - n*ln2
   f32e_fma #(.SB_W(66)) u_t (.clock, .reset, .en, .in_vld(v2),
      .a(n), .b(MINUS_LN2), .c(sb2[63:32]), .side_in(sb2),
      .out_vld(v3), .out_bits(t), .side_out(sb3));

   // first Horner step, and t*s alongside it
   f32e_fma #(.SB_W(66)) u_p4 (.clock, .reset, .en, .in_vld(v3),
      .a(COEF5), .b(t), .c(COEF4), .side_in({sb3[65:64], sb3[31:0], t}),
      .out_vld(v4), .out_bits(p4), .side_out(sb4));

   f32e_fma #(.SB_W(1)) u_ts (.clock, .reset, .en, .in_vld(v3),
      .a(t), .b(sb3[31:0]), .c(NEG_ZERO), .side_in(sb3[64]),
      .out_vld(v4b), .out_bits(ts), .side_out(sb4b));

   // sideband now carries cut, last, s, t and t*s
   assign sb5_in = {sb4, ts};

   f32e_fma #(.SB_W(98)) u_p5 (.clock, .reset, .en, .in_vld(v4),
      .a(p4), .b(sb5_in[63:32]), .c(COEF3), .side_in(sb5_in),
      .out_vld(v5), .out_bits(p5), .side_out(sb5));

   f32e_fma #(.SB_W(98)) u_p6 (.clock, .reset, .en, .in_vld(v5),
      .a(p5), .b(sb5[63:32]), .c(COEF2), .side_in(sb5),
      .out_vld(v6), .out_bits(p6), .side_out(sb6));

   f32e_fma #(.SB_W(98)) u_p7 (.clock, .reset, .en, .in_vld(v6),
      .a(p6), .b(sb6[63:32]), .c(COEF1), .side_in(sb6),
      .out_vld(v7), .out_bits(p7), .side_out(sb7));

   // f = s + (t*s)*p
   f32e_fma #(.SB_W(2)) u_f (.clock, .reset, .en, .in_vld(v7),
      .a(sb7[31:0]), .b(p7), .c(sb7[95:64]), .side_in(sb7[97:96]),
      .out_vld(v8), .out_bits(f), .side_out(sb8));

   // response word
   assign rsp_bus.valid    = v8;
   assign rsp_bus.y_bits   = sb8[1] ? 32'd0 : f;
   assign rsp_bus.last_out = sb8[0];

   // t*s unit runs in lockstep with the first Horner unit
   `F32E_ASSERT_NOW(a_ts_lockstep, v4 || v4b, v4 == v4b && sb4b == sb4[64])
   // a stall freezes the first Horner valid and the t*s result feeding the sideband
   `F32E_ASSERT_NEXT(a_stall_p4, !en, $stable(v4) && $stable(ts))
   // a stall freezes the operands of the final unit
   `F32E_ASSERT_NEXT(a_stall_p7, !en, $stable(v7) && $stable(p7))
endmodule
`default_nettype wire

>>> sim/tb_f32_exp_nonpositive_poly5_top.sv
// testbench for the single-precision exp pipeline: drives request words, predicts
// each response bit for bit with its own fused multiply-add model, checks in order
// depends on f32e_pkg, f32e_chan_if and f32_exp_nonpositive_poly5_top
`default_nettype none
module tb_f32_exp_nonpositive_poly5_top;
   import f32e_pkg::*;

   localparam int NUM_PHASES = 4;
   localparam int RANDOM_PER_PHASE = 135;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;

   // expected response word
   typedef struct packed {
      f32_type y_bits;
      logic    last_out;
   } exp_word_type;

   // in-order store of predicted exp results
   class exp_scoreboard;
      exp_word_type pending[$];
      int           errors;

      function new();
         errors = 0;
      endfunction

      static function bit is_nan(f32_type v);
         return v[30:0] > INF_MAG;
      endfunction

      static function bit is_inf(f32_type v);
         return v[30:0] == INF_MAG;
      endfunction

      static function bit is_zero(f32_type v);
         return v[30:0] == 31'd0;
      endfunction

      static function int top_bit(bit [63:0] v);
         int pos;
         pos = 0;
         for (int i = 1; i < 64; i++) begin
            if (v[i]) pos = i;
         end
         return pos;
      endfunction

      // round sign * s * 2^e to binary32, nearest even, subnormals kept
      static function f32_type round_to_f32(bit sign, bit [63:0] s, int e);
         int        msb_pos, ev, shift;
         bit        normal;
         bit [63:0] m, rem, half, w;
         msb_pos = top_bit(s);
         ev = msb_pos + e;
         normal = ev >= -126;
         shift = normal ? msb_pos - 23 : -149 - e;
         if (normal && ev + 127 >= 255) return {sign, INF_MAG};
         if (shift <= 0) begin
            m = s << (-shift);
         end else if (shift >= 64) begin
            m = 64'd0;
         end else begin
            rem = s & ((64'd1 << shift) - 64'd1);
            half = 64'd1 << (shift - 1);
            m = s >> shift;
            if (rem > half || (rem == half && m[0])) m = m + 64'd1;
         end
         if (normal) begin
            w = (64'(ev + 126) << 23) + m;
            if (w >= 64'(INF_MAG)) w = 64'(INF_MAG);
            return {sign, w[30:0]};
         end
         return {sign, m[30:0]};
      endfunction

      // a*b + c with one rounding
      static function f32_type fused_mac(f32_type a, f32_type b, f32_type c);
         bit        sp, sc, sbig, ssml;
         bit [63:0] ma, mb, mc, mp, big, sml, r;
         int        ea, eb, ec, ep, ebig, esml, d, ls;
         sp = a[31] ^ b[31];
         sc = c[31];
         if (is_nan(a)) return a | QUIET_BIT;
         if (is_nan(b)) return b | QUIET_BIT;
         if (is_nan(c)) return c | QUIET_BIT;
         if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return DEFAULT_NAN;
         if (is_inf(a) || is_inf(b)) begin
            if (is_inf(c) && sc != sp) return DEFAULT_NAN;
            return {sp, INF_MAG};
         end
         if (is_inf(c)) return c;
         if (is_zero(a) || is_zero(b)) begin
            if (!is_zero(c)) return c;
            return (sp == sc) ? c : 32'd0;
         end
         ma = {40'd0, a[30:23] != 8'd0, a[22:0]};
         ea = (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
         mb = {40'd0, b[30:23] != 8'd0, b[22:0]};
         eb = (b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150;
         mp = ma * mb;
         ep = ea + eb;
         if (is_zero(c)) return round_to_f32(sp, mp, ep);
         mc = {40'd0, c[30:23] != 8'd0, c[22:0]};
         ec = (c[30:23] == 8'd0) ? -149 : int'(c[30:23]) - 150;
         ls = 61 - top_bit(mp); mp = mp << ls; ep = ep - ls;
         ls = 61 - top_bit(mc); mc = mc << ls; ec = ec - ls;
         if (ep >= ec) begin
            big = mp; ebig = ep; sbig = sp; sml = mc; esml = ec; ssml = sc;
         end else begin
            big = mc; ebig = ec; sbig = sc; sml = mp; esml = ep; ssml = sp;
         end
         d = ebig - esml;
         // align the smaller addend, folding shifted-out bits into a sticky bit
         if (d >= 63) sml = (sml != 64'd0) ? 64'd1 : 64'd0;
         else sml = (sml >> d) | 64'((sml & ((64'd1 << d) - 64'd1)) != 64'd0);
         if (sbig == ssml) begin
            r = big + sml;
         end else if (big >= sml) begin
            r = big - sml;
         end else begin
            r = sml - big;
            sbig = ssml;
         end
         if (r == 64'd0) return 32'd0;
         return round_to_f32(sbig, r, ebig);
      endfunction

      // exp(x): range reduction, degree-5 polynomial, reconstruction
      static function f32_type predict_exp(f32_type x);
         f32_type vn, s, n, t, p, ts, f;
         vn = fused_mac(x, LOG2E, MAGIC_BIAS);
         s = vn << SCALE_SHIFT;
         if (is_nan(vn)) n = vn | QUIET_BIT;
         else if (is_nan(MAGIC_BIAS)) n = MAGIC_BIAS | QUIET_BIT;
         else n = fused_mac(vn, ONE_BITS, MAGIC_BIAS ^ NEG_ZERO);
         t = fused_mac(n, MINUS_LN2, x);
         p = fused_mac(COEF5, t, COEF4);
         p = fused_mac(p, t, COEF3);
         p = fused_mac(p, t, COEF2);
         p = fused_mac(p, t, COEF1);
         ts = fused_mac(t, s, NEG_ZERO);
         f = fused_mac(ts, p, s);
         // below the denormal cutoff, -inf included
         if (!is_nan(x) && x[31] && x[30:0] > CUTOFF_MAG) f = 32'd0;
         return f;
      endfunction

      function void note_request(f32_type x, logic last_in);
         exp_word_type w;
         w.y_bits = predict_exp(x);
         w.last_out = last_in;
         pending.push_back(w);
      endfunction

      function void check_response(f32_type y, logic last_out);
         exp_word_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response word y=%h last=%b", $time, y, last_out);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (y !== w.y_bits) begin
            $display("%0t: y_bits expected %h actual %h", $time, w.y_bits, y);
            errors++;
         end
         if (last_out !== w.last_out) begin
            $display("%0t: last_out expected %b actual %b", $time, w.last_out, last_out);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   f32e_req_if req_bus();
   f32e_rsp_if rsp_bus();

   f32_exp_nonpositive_poly5_top dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   exp_scoreboard board = new();
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // response side: random backpressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // accept monitor for both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) board.note_request(req_bus.x_bits, req_bus.last_in);
         if (rsp_bus.valid && rsp_bus.ready) board.check_response(rsp_bus.y_bits, rsp_bus.last_out);
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL f32_exp_nonpositive_poly5_top");
            $finish;
         end
      end
   end

   // present one word and hold it until accepted; each cycle idles with the set odds
   task automatic send_word(f32_type x, logic last_in);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.x_bits <= x;
      req_bus.last_in <= last_in;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // random operand, mostly inside the useful range [-87.34, 0]
   function automatic f32_type random_operand();
      f32_type v;
      v = $urandom();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            v[31] = 1'b1;
            v[30:23] = 8'($urandom_range(0, 133));
         end
         5: v = {1'b1, 31'(int'(CUTOFF_MAG) + $urandom_range(0, 16) - 8)};
         6: begin
            v[31] = 1'b1;
            v[30:23] = 8'($urandom_range(100, 126));
         end
         7: v[30:23] = 8'($urandom_range(0, 8));
         8: begin
            v[30:23] = 8'hFF;
            if ($urandom_range(0, 3) == 0) v[22:0] = 23'd0;
         end
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      f32_type directed[$];
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.x_bits = 32'd0;
      req_bus.last_in = 1'b0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zeros, infinities, nans, cutoff edges, typical and out-of-range values
      directed = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                   32'h7FC00000, 32'h7F800001, 32'hFFBFFFFF, 32'hFFFFFFFF,
                   32'hC2AEAC4F, 32'hC2AEAC50, 32'hC2AEAC4E, 32'hBF800000,
                   32'hC2AE0000, 32'h80000001, 32'h807FFFFF, 32'h00000001,
                   32'h3F800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'hBF317218,
                   32'hB3800000, 32'h42B00000, 32'hC1200000};
      foreach (directed[i]) send_word(directed[i], i[0]);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 81; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 81; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_word(random_operand(), $urandom_range(0, 1));
         end
      end
      req_bus.valid <= 1'b0;

      // drain everything in flight
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS f32_exp_nonpositive_poly5_top");
      end else begin
         $display("FAIL f32_exp_nonpositive_poly5_top");
      end
      $finish;
   end
endmodule
`default_nettype wire
